// ===== sv/rpd_pkg.sv =====
package rpd_pkg;

   localparam int unsigned LEN_W = 12;
   localparam int unsigned SUM_W = 8;
   localparam int unsigned BYTE_W = 8;

   localparam logic [BYTE_W-1:0] CH_INTR = 8'h03;
   localparam logic [BYTE_W-1:0] CH_START = 8'h24;
   localparam logic [BYTE_W-1:0] CH_END = 8'h23;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 12'd4095;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_BODY = 2'd1,
      PH_SUM_HI = 2'd2,
      PH_SUM_LO = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD = 3'd0,
      EV_ACK = 3'd1,
      EV_NACK = 3'd2,
      EV_INTR = 3'd3,
      EV_OVERFLOW = 3'd4
   } event_kind_type;

   // bit 4 marks a hex character, bits 3..0 hold its value
   function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
      logic [4:0] d;
      d = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b1, 4'(c - 8'h57)};
      end
      return d;
   endfunction

endpackage

// ===== sv/rsp_packet_deframer_top.sv =====
// channel  dir  ports                  contents
// req      in   req_tvalid/tready      tdata[7:0] rx_byte
// rsp      out  rsp_tvalid/tready      tuser[2:0] event_kind; tdata payload/length/sums
// csr      in   csr_we, csr_wdata      max_payload, 12 bits
//
// one byte a cycle: each byte goes through the phase logic in the cycle it is taken
// and its event (if any) lands in the output register on that edge
// req_tready is low only while an event is held in the output register and rsp_tready is low
// synchronous active-high reset: hunting, sums and counts cleared, max_payload 4095
module rsp_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] payload_byte, [19:8] packet_length,
                                    // [27:20] computed_sum, [35:28] received_sum, zero pad
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   input  logic        csr_we,
   input  logic [11:0] csr_wdata
);

   rpd_pkg::phase_type phase_ff, phase_in;
   logic [rpd_pkg::SUM_W-1:0] run_sum_ff, run_sum_in;
   logic [rpd_pkg::LEN_W-1:0] byte_count_ff, byte_count_in;
   logic [4:0] first_digit_ff, first_digit_in;
   logic [rpd_pkg::LEN_W-1:0] max_payload_ff;

   logic rsp_valid_ff, rsp_valid_in;
   rpd_pkg::event_kind_type rsp_kind_ff, rsp_kind_in;
   logic [rpd_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [rpd_pkg::LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic [rpd_pkg::SUM_W-1:0] rsp_csum_ff, rsp_csum_in;
   logic [rpd_pkg::SUM_W-1:0] rsp_rsum_ff, rsp_rsum_in;

   logic accept;
   logic emit;
   logic overflow;
   logic [4:0] digit;
   logic [rpd_pkg::SUM_W-1:0] rsum;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   assign digit = rpd_pkg::hex_digit(req_tdata);
   // one more byte would reach the limit
   assign overflow = ({1'b0, byte_count_ff} + 13'd1) >= {1'b0, max_payload_ff};

   always_comb begin
      if (!first_digit_ff[4]) begin
         rsum = '0;
      end else if (digit[4]) begin
         rsum = {first_digit_ff[3:0], digit[3:0]};
      end else begin
         rsum = {4'd0, first_digit_ff[3:0]};
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            rpd_pkg::PH_HUNT: begin
               if (req_tdata == rpd_pkg::CH_START) phase_in = rpd_pkg::PH_BODY;
            end
            rpd_pkg::PH_BODY: begin
               if (req_tdata == rpd_pkg::CH_END) begin
                  phase_in = rpd_pkg::PH_SUM_HI;
               end else if (overflow) begin
                  phase_in = rpd_pkg::PH_HUNT;
               end
            end
            rpd_pkg::PH_SUM_HI: phase_in = rpd_pkg::PH_SUM_LO;
            rpd_pkg::PH_SUM_LO: phase_in = rpd_pkg::PH_HUNT;
            default: phase_in = rpd_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath and event
   always_comb begin
      run_sum_in = run_sum_ff;
      byte_count_in = byte_count_ff;
      first_digit_in = first_digit_ff;
      emit = 1'b0;
      rsp_kind_in = rpd_pkg::EV_PAYLOAD;
      rsp_byte_in = '0;
      rsp_len_in = '0;
      rsp_csum_in = '0;
      rsp_rsum_in = '0;
      case (phase_ff)
         rpd_pkg::PH_HUNT: begin
            if (req_tdata == rpd_pkg::CH_INTR) begin
               emit = 1'b1;
               rsp_kind_in = rpd_pkg::EV_INTR;
            end else if (req_tdata == rpd_pkg::CH_START) begin
               run_sum_in = '0;
               byte_count_in = '0;
            end
         end
         rpd_pkg::PH_BODY: begin
            if (req_tdata == rpd_pkg::CH_END) begin
               emit = 1'b0;
            end else if (overflow) begin
               emit = 1'b1;
               rsp_kind_in = rpd_pkg::EV_OVERFLOW;
               rsp_len_in = byte_count_ff;
            end else begin
               emit = 1'b1;
               byte_count_in = byte_count_ff + 12'd1;
               run_sum_in = run_sum_ff + req_tdata;
               rsp_byte_in = req_tdata;
            end
         end
         rpd_pkg::PH_SUM_HI: begin
            first_digit_in = digit;
         end
         rpd_pkg::PH_SUM_LO: begin
            emit = 1'b1;
            rsp_kind_in = (rsum == run_sum_ff) ? rpd_pkg::EV_ACK : rpd_pkg::EV_NACK;
            rsp_len_in = byte_count_ff;
            rsp_csum_in = run_sum_ff;
            rsp_rsum_in = rsum;
         end
         default: emit = 1'b0;
      endcase
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rpd_pkg::PH_HUNT;
         run_sum_ff <= '0;
         byte_count_ff <= '0;
         first_digit_ff <= '0;
         max_payload_ff <= rpd_pkg::MAX_PAYLOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            run_sum_ff <= run_sum_in;
            byte_count_ff <= byte_count_in;
            first_digit_ff <= first_digit_in;
         end
         if (csr_we) max_payload_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_len_ff <= rsp_len_in;
         rsp_csum_ff <= rsp_csum_in;
         rsp_rsum_ff <= rsp_rsum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tdata = {4'd0, rsp_rsum_ff, rsp_csum_ff, rsp_len_ff, rsp_byte_ff};

`ifndef SYNTH
   // second checksum character always closes the packet with a verdict
   a_sum_lo_verdict: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == rpd_pkg::PH_SUM_LO |=>
         rsp_tvalid && phase_ff == rpd_pkg::PH_HUNT &&
         (rsp_tuser == rpd_pkg::EV_ACK || rsp_tuser == rpd_pkg::EV_NACK))
      else $error("checksum phase did not end in ack or nack");

   // packet start clears the running state
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == rpd_pkg::PH_HUNT && req_tdata == rpd_pkg::CH_START |=>
         phase_ff == rpd_pkg::PH_BODY && byte_count_ff == '0 && run_sum_ff == '0)
      else $error("packet start left stale sum or count");

   // payload words carry no length or sums
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rpd_pkg::EV_PAYLOAD |-> rsp_tdata[39:8] == '0)
      else $error("payload word carries length or sum bits");

   // a payload word means the count moved by one
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      accept && emit && rsp_kind_in == rpd_pkg::EV_PAYLOAD |=>
         byte_count_ff == $past(byte_count_ff) + 12'd1)
      else $error("payload byte did not advance the count");
`endif

endmodule

// ===== tb/sv/rsp_packet_deframer_top_test.sv =====
`timescale 1ns / 100ps

module rsp_packet_deframer_top_test;

   typedef struct packed {
      rpd_pkg::event_kind_type kind;
      logic [7:0]              data_byte;
      logic [11:0]             length;
      logic [7:0]              calc_sum;
      logic [7:0]              rx_sum;
   } frame_event_type;

   typedef enum int {TR_GOOD, TR_WRONG, TR_GARBAGE, TR_HALF} trailer_kind_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [11:0] csr_wdata;

   // deframer state as the stream should leave it
   rpd_pkg::phase_type rx_phase = rpd_pkg::PH_HUNT;
   logic [7:0]  body_sum = '0;
   logic [11:0] body_len = '0;
   logic [4:0]  hi_digit = '0;
   logic [11:0] len_limit = rpd_pkg::MAX_PAYLOAD_RESET;

   frame_event_type pending_events[$];
   bit  idle_on = 1'b1;
   int  bytes_sent = 0;
   int  bad_words = 0;
   int  limit_writes = 0;
   int  event_tally[0:4] = '{default: 0};

   rsp_packet_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int hex_nibble(input logic [7:0] ch);
      logic [7:0] folded;
      if (ch >= "0" && ch <= "9") begin
         return int'(ch - "0");
      end
      // only 'A'..'F' and 'a'..'f' land on 'a'..'f' after folding case
      folded = ch | 8'h20;
      if (folded >= "a" && folded <= "f") begin
         return int'(folded - "a") + 10;
      end
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) begin
         return 8'h30 + 8'(nib);
      end
      return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
   endfunction

   function automatic void deframe_byte(input logic [7:0] ch);
      frame_event_type ev;
      int              nib;
      logic [7:0]      got_sum;
      ev = '0;
      case (rx_phase)
         rpd_pkg::PH_HUNT: begin
            if (ch == rpd_pkg::CH_INTR) begin
               ev.kind = rpd_pkg::EV_INTR;
               pending_events.push_back(ev);
            end else if (ch == rpd_pkg::CH_START) begin
               rx_phase = rpd_pkg::PH_BODY;
               body_sum = '0;
               body_len = '0;
            end
         end
         rpd_pkg::PH_BODY: begin
            if (ch == rpd_pkg::CH_END) begin
               rx_phase = rpd_pkg::PH_SUM_HI;
            end else if ({1'b0, body_len} + 13'd1 >= {1'b0, len_limit}) begin
               rx_phase = rpd_pkg::PH_HUNT;
               ev.kind = rpd_pkg::EV_OVERFLOW;
               ev.length = body_len;
               pending_events.push_back(ev);
            end else begin
               body_len = body_len + 12'd1;
               body_sum = body_sum + ch;
               ev.kind = rpd_pkg::EV_PAYLOAD;
               ev.data_byte = ch;
               pending_events.push_back(ev);
            end
         end
         rpd_pkg::PH_SUM_HI: begin
            nib = hex_nibble(ch);
            hi_digit = (nib < 0) ? 5'd0 : {1'b1, 4'(nib)};
            rx_phase = rpd_pkg::PH_SUM_LO;
         end
         default: begin
            got_sum = '0;
            if (hi_digit[4]) begin
               nib = hex_nibble(ch);
               got_sum = {4'd0, hi_digit[3:0]};
               if (nib >= 0) begin
                  got_sum = {hi_digit[3:0], 4'(nib)};
               end
            end
            ev.kind = (got_sum == body_sum) ? rpd_pkg::EV_ACK : rpd_pkg::EV_NACK;
            ev.length = body_len;
            ev.calc_sum = body_sum;
            ev.rx_sum = got_sum;
            pending_events.push_back(ev);
            rx_phase = rpd_pkg::PH_HUNT;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         deframe_byte(req_tdata);
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            bad_words++;
            if (bad_words <= 10) begin
               $display("unexpected word: kind %0d tdata %h", rsp_tuser, rsp_tdata);
            end
         end else begin
            want = pending_events.pop_front();
            event_tally[want.kind]++;
            if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.data_byte
                || rsp_tdata[19:8] !== want.length || rsp_tdata[27:20] !== want.calc_sum
                || rsp_tdata[35:28] !== want.rx_sum) begin
               bad_words++;
               if (bad_words <= 10) begin
                  $display("mismatch: want kind %0d byte %h len %0d csum %h rsum %h",
                           want.kind, want.data_byte, want.length, want.calc_sum,
                           want.rx_sum);
                  $display("          got  kind %0d byte %h len %0d csum %h rsum %h",
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[19:8], rsp_tdata[27:20],
                           rsp_tdata[35:28]);
               end
            end
         end
      end
   end

   // receiver back-pressure
   always begin : rsp_stall
      int stall;
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready && !reset));
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // first edge lets the last accepted word reach the predictor
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [11:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      len_limit = v;
      limit_writes++;
      csr_we <= 1'b0;
   endtask

   task automatic send_packet(input int len, input trailer_kind_type trailer);
      logic [7:0] acc;
      logic [7:0] ch;
      logic [7:0] ck;
      acc = '0;
      send_byte(rpd_pkg::CH_START);
      for (int i = 0; i < len; i++) begin
         ch = 8'($urandom);
         if (ch == rpd_pkg::CH_END) ch = ch ^ 8'h01;  // keep the body going
         acc = acc + ch;
         send_byte(ch);
      end
      send_byte(rpd_pkg::CH_END);
      case (trailer)
         TR_GOOD:  ck = acc;
         TR_WRONG: ck = acc ^ 8'($urandom_range(1, 255));
         default:  ck = 8'($urandom);
      endcase
      if (trailer == TR_GARBAGE) begin
         send_byte(8'($urandom));
         send_byte(8'($urandom));
      end else if (trailer == TR_HALF) begin
         send_byte(hex_char(ck[7:4], 1'($urandom_range(0, 1))));
         send_byte(8'($urandom));
      end else begin
         send_byte(hex_char(ck[7:4], 1'($urandom_range(0, 1))));
         send_byte(hex_char(ck[3:0], 1'($urandom_range(0, 1))));
      end
   endtask

   task automatic test_hunting();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(rpd_pkg::CH_INTR);
      send_byte(rpd_pkg::CH_END);
      send_byte(rpd_pkg::CH_INTR);
   endtask

   task automatic test_checksum_forms();
      // interrupt and start characters inside a body are plain payload
      send_byte(rpd_pkg::CH_START);
      send_byte(rpd_pkg::CH_INTR);
      send_byte(rpd_pkg::CH_START);
      send_byte(8'hFF);
      send_byte(rpd_pkg::CH_END);
      send_byte("2");
      send_byte("6");
      // mixed case digits
      send_byte(rpd_pkg::CH_START);
      send_byte(8'hBC);
      send_byte(rpd_pkg::CH_END);
      send_byte("b");
      send_byte("C");
      // hash as first checksum char: not hex, so the sum reads as zero
      send_byte(rpd_pkg::CH_START);
      send_byte(rpd_pkg::CH_END);
      send_byte(rpd_pkg::CH_END);
      send_byte("0");
      // bad second char keeps the first digit only
      send_byte(rpd_pkg::CH_START);
      send_byte(8'h41);
      send_byte(rpd_pkg::CH_END);
      send_byte("7");
      send_byte("g");
   endtask

   task automatic test_payload_limit();
      set_limit(12'd1);
      send_byte(rpd_pkg::CH_START);
      send_byte(8'h55);
      set_limit(12'd3);
      send_byte(rpd_pkg::CH_START);
      send_byte("a");
      send_byte("b");
      send_byte("c");
      set_limit(12'd0);
      send_byte(rpd_pkg::CH_START);
      send_byte(8'h00);
   endtask

   task automatic run_random(input int n);
      int               start;
      int               r;
      int               len;
      trailer_kind_type tr;
      start = bytes_sent;
      while (bytes_sent - start < n) begin
         if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
         r = $urandom_range(0, 99);
         if (r < 20) begin
            // line noise, some of it interrupts
            repeat ($urandom_range(1, 5)) begin
               send_byte(($urandom_range(0, 2) == 0) ? rpd_pkg::CH_INTR : 8'($urandom));
            end
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                               : $urandom_range(0, 12);
            r = $urandom_range(0, 99);
            tr = (r < 60) ? TR_GOOD : (r < 75) ? TR_WRONG : (r < 88) ? TR_GARBAGE : TR_HALF;
            send_packet(len, tr);
         end
         if ($urandom_range(0, 11) == 0) wait_drained();
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_random(150);
      set_limit(12'd20);
      run_random(150);
      set_limit(12'd7);
      run_random(150);
      set_limit(12'd1);
      run_random(80);
      set_limit(12'($urandom_range(2, 40)));
      run_random(150);
      set_limit(12'hA5A);
      run_random(80);
      set_limit(rpd_pkg::MAX_PAYLOAD_RESET);
      run_random(150);
   endtask

   // longest legal packet under a short limit, then one byte more
   task automatic test_full_length();
      set_limit(12'd64);
      idle_on = 1'b0;
      send_packet(63, TR_GOOD);
      send_packet(64, TR_GOOD);
      wait_drained();
      idle_on = 1'b1;
   endtask

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hunting();
      test_checksum_forms();
      test_payload_limit();
      set_limit(rpd_pkg::MAX_PAYLOAD_RESET);
      test_random_traffic();
      test_full_length();
      wait_drained();
      $display("%0d bytes in, %0d limit writes; events: payload %0d ack %0d nack %0d",
               bytes_sent, limit_writes, event_tally[0], event_tally[1], event_tally[2]);
      $display("interrupt %0d overflow %0d, %0d bad words",
               event_tally[3], event_tally[4], bad_words);
      if (bad_words == 0 && pending_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== rsp_packet_deframer_top.f =====
sv/rpd_pkg.sv
sv/rsp_packet_deframer_top.sv
tb/sv/rsp_packet_deframer_top_test.sv
